// ===== hw/rtl/mlnp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlnp_pkg - shared definitions for the mono last-note-priority core
// Opcodes, result actions, register indexes and the held-note entry type.
// ----------------------------------------------------------------------------
package mlnp_pkg;

    localparam int STACK_DEPTH_DEF = 128;

    // event opcodes; the unused fourth code behaves as all notes off
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_ALL_OFF  = 2'd2;

    // result actions
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_CHANGE = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W        = 2;
    localparam logic [1:0] CFG_GLIDE_ON     = 2'd0;
    localparam logic [1:0] CFG_GLIDE_ALWAYS = 2'd1;
    localparam logic [1:0] CFG_LEGATO       = 2'd2;

    typedef struct packed {
        logic [6:0] note;
        logic [6:0] velocity;
        logic [4:0] channel;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== hw/rtl/mono_last_note_priority_core.sv =====
// ----------------------------------------------------------------------------
// mono_last_note_priority_core - monophonic last-note-priority voice control
// Held-note stack in RAM, compacted by a sequencer with one compare unit.
// ----------------------------------------------------------------------------
// Usage: raise start with an event while busy is low; the transaction is taken
// at that edge. Every event produces exactly one result, shown for a single
// cycle with o_strobe high; the receiver cannot stall, so sample it then.
// An all-notes-off event completes at once; its result is registered and shows
// in the cycle after start. A note-on holds busy high while the stack is
// scanned, plus a second, shifting pass when the stack is full, holds no copy
// of the note and the oldest entry must be dropped. A note-off holds busy high
// while the stack is scanned and, when a note remains to fall back to, while
// the newest entry is read back. The result shows in the first cycle with
// busy low again. The scan time is set by the stack RAM: one entry is read
// and compared per cycle while matching copies are squeezed out. No clearing
// pass follows reset: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module mono_last_note_priority_core
    import mlnp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event channel
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_opcode,
    input  logic [6:0]           i_note,
    input  logic [6:0]           i_velocity,
    input  logic [4:0]           i_channel,
    input  logic                 i_allow_tail_off,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data,
    // result channel
    output logic                 o_strobe,
    output logic [1:0]           o_action,
    output logic [6:0]           o_out_note,
    output logic [6:0]           o_out_velocity,
    output logic [4:0]           o_out_channel,
    output logic                 o_glide_valid,
    output logic [6:0]           o_glide_from_note,
    output logic                 o_tail_off
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_PUSH    = 3'd2;
    localparam logic [2:0] S_TOPRD   = 3'd3;
    localparam logic [2:0] S_TOPWAIT = 3'd4;

    // control state
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;       // held entries
    logic [CW-1:0] r_rd, n_rd;         // next entry to read
    logic [CW-1:0] r_w, n_w;           // next compacted slot
    logic          r_pv, n_pv;         // read data arrives this cycle
    logic          r_nodrop, n_nodrop; // shift pass: keep every entry
    logic          r_last_vld, n_last_vld;
    logic [6:0]    r_last_note, n_last_note;
    logic          r_glide_on, n_glide_on;
    logic          r_glide_alw, n_glide_alw;
    logic          r_legato, n_legato;
    logic          r_strobe, n_strobe;

    // captured transaction
    logic [1:0]    r_op, n_op;
    t_entry        r_ev, n_ev;
    logic          r_tail, n_tail;
    logic          r_was_hold, n_was_hold;

    // result payload
    logic [1:0]    r_action, n_action;
    t_entry        r_res, n_res;
    logic          r_gv, n_gv;
    logic [6:0]    r_gfrom, n_gfrom;
    logic          r_otail, n_otail;

    // stack RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_rdata;

    logic          issue;
    logic          hit;
    logic          accept;

    mlnp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign issue  = (r_rd < r_cnt);
    // a copy of the event's note on the event's channel
    assign hit    = (ram_rdata.note == r_ev.note) && (ram_rdata.channel == r_ev.channel);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd        = r_rd;
        n_w         = r_w;
        n_pv        = 1'b0;
        n_nodrop    = r_nodrop;
        n_last_vld  = r_last_vld;
        n_last_note = r_last_note;
        n_glide_on  = r_glide_on;
        n_glide_alw = r_glide_alw;
        n_legato    = r_legato;
        n_strobe    = 1'b0;
        n_op        = r_op;
        n_ev        = r_ev;
        n_tail      = r_tail;
        n_was_hold  = r_was_hold;
        n_action    = r_action;
        n_res       = r_res;
        n_gv        = r_gv;
        n_gfrom     = r_gfrom;
        n_otail     = r_otail;

        ram_we      = 1'b0;
        ram_waddr   = r_w[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = r_rd[AW-1:0];

        // configuration writes are for the user to make only while idle; the core does not enforce it
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GLIDE_ON:     n_glide_on  = i_cfg_data;
                CFG_GLIDE_ALWAYS: n_glide_alw = i_cfg_data;
                CFG_LEGATO:       n_legato    = i_cfg_data;
                default:          ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op       = i_opcode;
                    n_ev       = '{note: i_note, velocity: i_velocity, channel: i_channel};
                    n_tail     = i_allow_tail_off;
                    n_was_hold = (r_cnt != '0);
                    n_rd       = '0;
                    n_w        = '0;
                    n_nodrop   = 1'b0;
                    unique case (i_opcode)
                        OP_NOTE_ON, OP_NOTE_OFF: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            // all notes off: empty the stack, forget the last note
                            n_cnt       = '0;
                            n_last_vld  = 1'b0;
                            n_last_note = '0;
                            n_strobe    = 1'b1;
                            n_action    = ACT_STOP;
                            n_res       = '0;
                            n_gv        = 1'b0;
                            n_gfrom     = '0;
                            n_otail     = i_allow_tail_off;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // read one entry a cycle, write survivors down to the compacted slot
                if (issue) begin
                    n_rd = r_rd + CW'(1);
                    n_pv = 1'b1;
                end
                if (r_pv && (r_nodrop || !hit)) begin
                    ram_we = 1'b1;
                    n_w    = r_w + CW'(1);
                end
                if (!issue && !r_pv) begin
                    n_cnt = r_w;
                    if (r_op == OP_NOTE_ON) begin
                        if (!r_nodrop && (r_w == CW'(STACK_DEPTH))) begin
                            // full: shift everything down one to drop the oldest
                            n_nodrop = 1'b1;
                            n_rd     = CW'(1);
                            n_w      = '0;
                        end else begin
                            n_state = S_PUSH;
                        end
                    end else if (r_w == '0) begin
                        // nothing left held: stop, keep the last note
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                        n_action = ACT_STOP;
                        n_res    = '0;
                        n_gv     = 1'b0;
                        n_gfrom  = '0;
                        n_otail  = r_tail;
                    end else begin
                        n_state = S_TOPRD;
                    end
                end
            end

            S_PUSH: begin
                ram_we      = 1'b1;
                ram_waddr   = r_cnt[AW-1:0];
                ram_wdata   = r_ev;
                n_cnt       = r_cnt + CW'(1);
                n_state     = S_IDLE;
                n_strobe    = 1'b1;
                n_action    = (r_legato && r_was_hold) ? ACT_CHANGE : ACT_START;
                n_res       = r_ev;
                n_gv        = r_glide_on && (r_glide_alw || r_was_hold) && r_last_vld;
                n_gfrom     = n_gv ? r_last_note : '0;
                n_otail     = 1'b0;
                n_last_vld  = 1'b1;
                n_last_note = r_ev.note;
            end

            S_TOPRD: begin
                ram_raddr = AW'(r_cnt - CW'(1));
                n_state   = S_TOPWAIT;
            end

            S_TOPWAIT: begin
                // fall back to the newest remaining note
                n_state     = S_IDLE;
                n_strobe    = 1'b1;
                n_action    = ACT_CHANGE;
                n_res       = ram_rdata;
                n_gv        = r_glide_on && r_last_vld;
                n_gfrom     = n_gv ? r_last_note : '0;
                n_otail     = 1'b0;
                n_last_vld  = 1'b1;
                n_last_note = ram_rdata.note;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rd        <= '0;
            r_w         <= '0;
            r_pv        <= 1'b0;
            r_nodrop    <= 1'b0;
            r_last_vld  <= 1'b0;
            r_last_note <= '0;
            r_glide_on  <= 1'b0;
            r_glide_alw <= 1'b0;
            r_legato    <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd        <= n_rd;
            r_w         <= n_w;
            r_pv        <= n_pv;
            r_nodrop    <= n_nodrop;
            r_last_vld  <= n_last_vld;
            r_last_note <= n_last_note;
            r_glide_on  <= n_glide_on;
            r_glide_alw <= n_glide_alw;
            r_legato    <= n_legato;
            r_strobe    <= n_strobe;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ev       <= n_ev;
        r_tail     <= n_tail;
        r_was_hold <= n_was_hold;
        r_action   <= n_action;
        r_res      <= n_res;
        r_gv       <= n_gv;
        r_gfrom    <= n_gfrom;
        r_otail    <= n_otail;
    end

    assign o_strobe          = r_strobe;
    assign o_action          = r_action;
    assign o_out_note        = r_res.note;
    assign o_out_velocity    = r_res.velocity;
    assign o_out_channel     = r_res.channel;
    assign o_glide_valid     = r_gv;
    assign o_glide_from_note = r_gfrom;
    assign o_tail_off        = r_otail;

endmodule

// ===== hw/rtl/mlnp_ram.sv =====
// ----------------------------------------------------------------------------
// mlnp_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/mlnp_checker.sv =====
// ----------------------------------------------------------------------------
// mlnp_checker - port-level checks for the mono last-note-priority core
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module mlnp_checker
    import mlnp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [1:0]           i_opcode,
    input logic                 i_allow_tail_off,
    input logic                 o_strobe,
    input logic [1:0]           o_action,
    input logic [6:0]           o_out_note,
    input logic [6:0]           o_out_velocity,
    input logic [4:0]           o_out_channel,
    input logic                 o_glide_valid,
    input logic [6:0]           o_glide_from_note,
    input logic                 o_tail_off
);

    // a result always lands with the core free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // note events hold the core for the stack walk
    a_note_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_NOTE_ON || i_opcode == OP_NOTE_OFF)) |=> busy)
        else $error("note event did not occupy the core");

    // all notes off answers at once with a stop carrying the tail flag
    a_all_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode != OP_NOTE_ON && i_opcode != OP_NOTE_OFF) |=>
        (o_strobe && o_action == ACT_STOP && o_tail_off == $past(i_allow_tail_off)))
        else $error("all notes off not answered with a stop");

    // a stop carries no pitch and no glide
    a_stop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_action == ACT_STOP) |->
        (!o_glide_valid && o_out_note == 7'd0 && o_out_velocity == 7'd0 &&
         o_out_channel == 5'd0))
        else $error("stop result carries note data");

    // without glide the origin reads zero, and only a stop may set tail_off
    a_glide_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (!o_glide_valid || o_action != ACT_STOP)) |->
        ((o_glide_valid || o_glide_from_note == 7'd0) &&
         (o_action == ACT_STOP || !o_tail_off)))
        else $error("glide origin or tail flag not cleared");

endmodule

bind mono_last_note_priority_core mlnp_checker u_mlnp_checker (.*);

// ===== tb/mlnp_voice_checker.sv =====
// ----------------------------------------------------------------------------
// mlnp_voice_checker - result checker for the mono last-note-priority core
// Watches the event, configuration and result ports, keeps its own held-note
// stack and voice state, and compares every result with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module mlnp_voice_checker
    import mlnp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event channel
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [1:0]           i_opcode,
    input  logic [6:0]           i_note,
    input  logic [6:0]           i_velocity,
    input  logic [4:0]           i_channel,
    input  logic                 i_allow_tail_off,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data,
    // result channel
    input  logic                 i_strobe,
    input  logic [1:0]           i_action,
    input  logic [6:0]           i_out_note,
    input  logic [6:0]           i_out_velocity,
    input  logic [4:0]           i_out_channel,
    input  logic                 i_glide_valid,
    input  logic [6:0]           i_glide_from_note,
    input  logic                 i_tail_off,
    // status towards the testbench top
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [4:0] channel;
        logic       glide;
        logic [6:0] glide_from;
        logic       tail;
    } t_voice_cmd;

    t_entry     held_notes [STACK_DEPTH];
    int         held_cnt;
    logic       voice_known;
    logic [6:0] voice_note;
    logic       glide_on;
    logic       glide_always;
    logic       legato;
    t_voice_cmd voice_cmds [$];

    initial o_fail_count = 0;
    initial o_pending    = 0;

    // squeeze out every held copy of this note on this channel
    function automatic void drop_copies(logic [6:0] note, logic [4:0] channel);
        int keep = 0;
        for (int r = 0; r < held_cnt; r++) begin
            if (!(held_notes[r].note == note && held_notes[r].channel == channel)) begin
                held_notes[keep] = held_notes[r];
                keep++;
            end
        end
        held_cnt = keep;
    endfunction

    function automatic void predict_voice_cmd(logic [1:0] opcode, logic [6:0] note,
                                              logic [6:0] velocity, logic [4:0] channel,
                                              logic tail);
        t_voice_cmd cmd = '0;
        logic       was_holding;
        if (opcode == OP_NOTE_ON) begin
            was_holding = (held_cnt > 0);
            drop_copies(note, channel);
            if (held_cnt >= STACK_DEPTH) begin
                for (int i = 0; i < STACK_DEPTH - 1; i++)
                    held_notes[i] = held_notes[i + 1];
                held_cnt = STACK_DEPTH - 1;
            end
            held_notes[held_cnt] = '{note: note, velocity: velocity, channel: channel};
            held_cnt++;
            cmd.action   = (legato && was_holding) ? ACT_CHANGE : ACT_START;
            cmd.note     = note;
            cmd.velocity = velocity;
            cmd.channel  = channel;
            if (glide_on && (glide_always || was_holding) && voice_known) begin
                cmd.glide      = 1'b1;
                cmd.glide_from = voice_note;
            end
            voice_known = 1'b1;
            voice_note  = note;
        end else if (opcode == OP_NOTE_OFF) begin
            drop_copies(note, channel);
            if (held_cnt == 0) begin
                // a stop after note-off keeps the last sounding note
                cmd.action = ACT_STOP;
                cmd.tail   = tail;
            end else begin
                cmd.action   = ACT_CHANGE;
                cmd.note     = held_notes[held_cnt - 1].note;
                cmd.velocity = held_notes[held_cnt - 1].velocity;
                cmd.channel  = held_notes[held_cnt - 1].channel;
                if (glide_on && voice_known) begin
                    cmd.glide      = 1'b1;
                    cmd.glide_from = voice_note;
                end
                voice_known = 1'b1;
                voice_note  = cmd.note;
            end
        end else begin
            // all notes off, and the unused code with it
            held_cnt    = 0;
            voice_known = 1'b0;
            voice_note  = '0;
            cmd.action  = ACT_STOP;
            cmd.tail    = tail;
        end
        voice_cmds.push_back(cmd);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_voice_cmd want;
        if (!i_rst_n) begin
            held_cnt     = 0;
            voice_known  = 1'b0;
            voice_note   = '0;
            glide_on     = 1'b0;
            glide_always = 1'b0;
            legato       = 1'b0;
            voice_cmds.delete();
        end else begin
            if (i_strobe) begin
                if (voice_cmds.size() == 0) begin
                    $display("%0t: unexpected result, action %0d note %0d", $time,
                             i_action, i_out_note);
                    o_fail_count++;
                end else begin
                    want = voice_cmds.pop_front();
                    check_field("action", want.action, i_action);
                    check_field("out_note", want.note, i_out_note);
                    check_field("out_velocity", want.velocity, i_out_velocity);
                    check_field("out_channel", want.channel, i_out_channel);
                    check_field("glide_valid", want.glide, i_glide_valid);
                    check_field("glide_from_note", want.glide_from, i_glide_from_note);
                    check_field("tail_off", want.tail, i_tail_off);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GLIDE_ON:     glide_on     = i_cfg_data;
                    CFG_GLIDE_ALWAYS: glide_always = i_cfg_data;
                    CFG_LEGATO:       legato       = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                predict_voice_cmd(i_opcode, i_note, i_velocity, i_channel, i_allow_tail_off);
        end
        o_pending <= voice_cmds.size();
    end

endmodule

// ===== tb/tb_mono_last_note_priority_core.sv =====
// ----------------------------------------------------------------------------
// tb_mono_last_note_priority_core - testbench for the mono last-note core
// Drives directed and random note-on, note-off and all-notes-off events under
// every combination of glide and legato settings, with phases of sender idling
// and bursts that fill the held-note stack past its depth. A separate checker
// predicts and compares every result; this top makes stimulus and reports status.
// ----------------------------------------------------------------------------
module tb_mono_last_note_priority_core;
    import mlnp_pkg::*;

    localparam int STALL_LIMIT = 5000;  // cycles with no transaction at all
    localparam int END_PAUSE   = 300;   // longer than the slowest event

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 start            = 1'b0;
    logic                 busy;
    logic [1:0]           i_opcode         = '0;
    logic [6:0]           i_note           = '0;
    logic [6:0]           i_velocity       = '0;
    logic [4:0]           i_channel        = '0;
    logic                 i_allow_tail_off = 1'b0;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx        = '0;
    logic                 i_cfg_data       = 1'b0;
    logic                 o_strobe;
    logic [1:0]           o_action;
    logic [6:0]           o_out_note;
    logic [6:0]           o_out_velocity;
    logic [4:0]           o_out_channel;
    logic                 o_glide_valid;
    logic [6:0]           o_glide_from_note;
    logic                 o_tail_off;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int sender_idle_pct = 0;
    int note_base = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    mono_last_note_priority_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_note            (i_note),
        .i_velocity        (i_velocity),
        .i_channel         (i_channel),
        .i_allow_tail_off  (i_allow_tail_off),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_action          (o_action),
        .o_out_note        (o_out_note),
        .o_out_velocity    (o_out_velocity),
        .o_out_channel     (o_out_channel),
        .o_glide_valid     (o_glide_valid),
        .o_glide_from_note (o_glide_from_note),
        .o_tail_off        (o_tail_off)
    );

    mlnp_voice_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_opcode          (i_opcode),
        .i_note            (i_note),
        .i_velocity        (i_velocity),
        .i_channel         (i_channel),
        .i_allow_tail_off  (i_allow_tail_off),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_strobe          (o_strobe),
        .i_action          (o_action),
        .i_out_note        (o_out_note),
        .i_out_velocity    (o_out_velocity),
        .i_out_channel     (o_out_channel),
        .i_glide_valid     (o_glide_valid),
        .i_glide_from_note (o_glide_from_note),
        .i_tail_off        (o_tail_off),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Watchdog: count cycles in which neither an event nor a result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one event and hold it until the core takes it. Start is left high
    // on return, so a back-to-back event simply replaces the fields.
    task automatic send_event(logic [1:0] opcode, logic [6:0] note, logic [6:0] velocity,
                              logic [4:0] channel, logic tail);
        int gap;
        // occasional long pause so that the next start lands on any phase
        gap = ($urandom_range(99) < sender_idle_pct / 10) ? $urandom_range(1, 300) : 0;
        while (gap > 0 || $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            if (gap > 0)
                gap--;
        end
        start            <= 1'b1;
        i_opcode         <= opcode;
        i_note           <= note;
        i_velocity       <= velocity;
        i_channel        <= channel;
        i_allow_tail_off <= tail;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Drop start and hold until every outstanding result has arrived.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || pending != 0)
            @(posedge i_clk);
    endtask

    // Write all three voice registers on consecutive cycles; only call idle.
    task automatic program_voice(logic glide, logic glide_all, logic legato);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_GLIDE_ON;
        i_cfg_data <= glide;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GLIDE_ALWAYS;
        i_cfg_data <= glide_all;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LEGATO;
        i_cfg_data <= legato;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly playing on a narrow keyboard window and two channels, so that
    // note-offs find their notes; the rest is noise across every field value.
    task automatic send_random_event();
        int         pick;
        logic [1:0] opcode;
        logic [6:0] note;
        logic [4:0] channel;
        pick = $urandom_range(99);
        if (pick < 50)      opcode = OP_NOTE_ON;
        else if (pick < 88) opcode = OP_NOTE_OFF;
        else if (pick < 96) opcode = OP_ALL_OFF;
        else                opcode = 2'd3;
        if ($urandom_range(99) < 15) begin
            note    = $urandom_range(0, 127);
            channel = $urandom_range(0, 31);
        end else begin
            note    = note_base + $urandom_range(0, 7);
            channel = $urandom_range(1, 2);
        end
        send_event(opcode, note, $urandom_range(0, 127), channel, $urandom_range(0, 1));
    endtask

    // Push more distinct notes than the stack holds so the oldest get
    // dropped, then release random notes on both channels, starting from a full stack.
    task automatic fill_stack();
        for (int i = 0; i < 140; i++)
            send_event(OP_NOTE_ON, i[6:0], $urandom_range(0, 127), (i < 128) ? 5'd1 : 5'd2,
                       $urandom_range(0, 1));
        for (int i = 0; i < 20; i++)
            send_event(OP_NOTE_OFF, $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(1, 2), $urandom_range(0, 1));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: legato with glide, glide only while holding.
        program_voice(1'b1, 1'b0, 1'b1);
        send_event(OP_NOTE_OFF, 7'd5, 7'd9, 5'd1, 1'b1);       // release with nothing held
        send_event(OP_ALL_OFF, 7'd0, 7'd0, 5'd0, 1'b0);
        send_event(OP_NOTE_ON, 7'd0, 7'd0, 5'd0, 1'b1);        // lowest fields, no prior note
        send_event(OP_NOTE_ON, 7'd127, 7'd127, 5'd31, 1'b1);  // highest fields, legato glide
        send_event(OP_NOTE_ON, 7'd0, 7'd64, 5'd0, 1'b0);       // same note again moves to top
        send_event(OP_NOTE_OFF, 7'd60, 7'd3, 5'd1, 1'b1);      // release of a note not held
        send_event(OP_NOTE_OFF, 7'd0, 7'd0, 5'd0, 1'b0);       // fall back to the older note
        send_event(OP_NOTE_OFF, 7'd127, 7'd127, 5'd31, 1'b1); // last one out stops
        send_event(OP_NOTE_ON, 7'd64, 7'd100, 5'd16, 1'b0);    // after silence: fresh start
        send_event(OP_NOTE_ON, 7'd64, 7'd1, 5'd1, 1'b0);       // same note, other channel
        send_event(2'd3, 7'd85, 7'd42, 5'd17, 1'b1);           // unused code clears all
        send_event(OP_NOTE_OFF, 7'd64, 7'd0, 5'd16, 1'b0);
        drain();

        // Directed: retrigger mode, glide always.
        program_voice(1'b1, 1'b1, 1'b0);
        send_event(OP_NOTE_ON, 7'd50, 7'd80, 5'd3, 1'b0);      // no glide after all off
        send_event(OP_NOTE_OFF, 7'd50, 7'd80, 5'd3, 1'b0);
        send_event(OP_NOTE_ON, 7'd51, 7'd81, 5'd3, 1'b1);      // glides from the silent note
        send_event(OP_NOTE_ON, 7'd52, 7'd82, 5'd4, 1'b0);      // held, yet a full retrigger
        send_event(OP_ALL_OFF, 7'd42, 7'd21, 5'd10, 1'b1);
        drain();

        // Random phases: every register setting, three sender idling levels.
        for (int blk = 0; blk < 8; blk++) begin
            case (blk % 3)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 60;
                default: sender_idle_pct = 13;
            endcase
            note_base = $urandom_range(0, 120);
            drain();
            program_voice(blk[0], blk[1], blk[2]);
            if (blk % 3 == 1) begin
                fill_stack();
                repeat (40) send_random_event();
            end else begin
                repeat (200) send_random_event();
            end
        end

        drain();
        repeat (END_PAUSE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== mono_last_note_priority_core.f =====
hw/rtl/mlnp_pkg.sv
hw/rtl/mlnp_ram.sv
hw/rtl/mono_last_note_priority_core.sv
hw/rtl/mlnp_checker.sv
tb/mlnp_voice_checker.sv
tb/tb_mono_last_note_priority_core.sv
